// ----- rtl/atl_pkg.sv -----
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types, widths, constants and helpers of the tilt angle block.
// ----------------------------------------------------------------------------
package atl_pkg;

  // defaults for the top level parameters
  localparam int FRAC_BITS_DEF     = 8;
  localparam int CORDIC_STAGES_DEF = 16;

  // register and axis widths
  localparam int AXIS_W  = 16;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 14;
  localparam int CFG_W   = 16;

  // mapping datapath widths
  localparam int DIFF_W  = 17;   // raw minus in_low, and in_high minus in_low
  localparam int RNG_W   = 15;   // out_high minus out_low
  localparam int PROD_W  = 32;
  localparam int MAG_W   = 29;   // magnitude of the dividend
  localparam int DEN_W   = 16;   // magnitude of the divisor
  localparam int MAP_W   = 31;

  // square root widths
  localparam int SQ_W       = 32;
  localparam int SQN_W      = 34;
  localparam int SQRT_STEPS = 17;
  localparam int ROOT_W     = 17;

  // cordic widths
  localparam int OP_W        = 18;
  localparam int CW          = 32;
  localparam int ZW          = 26;
  localparam int TAB_LEN     = 24;
  localparam int PRESCALE_SH = 12;
  localparam int ANG_FRAC    = 16;

  localparam logic signed [ZW-1:0] DEG_90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * 65536);

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
    ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
    ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
    ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
    ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
    ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IN_LOW   = 2'd0,
    CFG_IN_HIGH  = 2'd1,
    CFG_OUT_LOW  = 2'd2,
    CFG_OUT_HIGH = 2'd3
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } accel_in_t;

  // result beat
  typedef struct packed {
    logic signed [15:0] tilt_about_x;
    logic signed [15:0] tilt_about_y;
    logic [16:0]        plane_angle;
    logic               range_error;
  } tilt_out_t;

  // divider cell state
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [MAG_W-1:0] nq;
  } div_t;

  // square root cell state
  typedef struct packed {
    logic [SQN_W-1:0] n;
    logic [SQN_W-1:0] r;
  } sqrt_t;

  // cordic cell state
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    cordic_t              st;
    logic                 sp;
    logic signed [ZW-1:0] sp_z;
  } cordic_prep_t;

  // prescale, pre-rotate into the right half plane, flag axis cases
  function automatic cordic_prep_t cordic_prep(input logic signed [OP_W-1:0] y,
                                               input logic signed [OP_W-1:0] x);
    cordic_prep_t         p;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs     = CW'(x) <<< PRESCALE_SH;
    ys     = CW'(y) <<< PRESCALE_SH;
    p.sp   = 1'b0;
    p.sp_z = '0;
    if (y == '0) begin
      p.sp   = 1'b1;
      p.sp_z = x[OP_W-1] ? DEG_180 : '0;
    end else if (x == '0) begin
      p.sp   = 1'b1;
      p.sp_z = y[OP_W-1] ? -DEG_90 : DEG_90;
    end
    p.st.x = xs;
    p.st.y = ys;
    p.st.z = '0;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        p.st.x = ys;
        p.st.y = -xs;
        p.st.z = DEG_90;
      end else begin
        p.st.x = -ys;
        p.st.y = xs;
        p.st.z = -DEG_90;
      end
    end
    return p;
  endfunction

endpackage

// ----- rtl/atl_div_cell.sv -----
// ----------------------------------------------------------------------------
// atl_div_cell
// One restoring division step: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atl_div_cell import atl_pkg::*; (
  input  logic             clk_i,
  input  div_t             st_i,
  input  logic [DEN_W-1:0] den_i,
  output div_t             st_o
);

  div_t           st_d;
  div_t           st_q;
  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  // trial subtract of the divisor
  always_comb begin
    shifted    = {st_i.rem, st_i.nq[MAG_W-1]};
    diff       = shifted - {1'b0, den_i};
    ge         = (shifted >= {1'b0, den_i});
    st_d.rem   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    st_d.nq    = {st_i.nq[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ----- rtl/atl_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// atl_sqrt_cell
// One step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module atl_sqrt_cell import atl_pkg::*; #(
  parameter int BIT_POS = 0
) (
  input  logic  clk_i,
  input  sqrt_t st_i,
  output sqrt_t st_o
);

  localparam logic [SQN_W-1:0] BIT = {{(SQN_W-1){1'b0}}, 1'b1} << BIT_POS;

  sqrt_t            st_d;
  sqrt_t            st_q;
  logic [SQN_W-1:0] trial;
  logic             ge;

  // compare against root plus the current bit
  always_comb begin
    trial = st_i.r + BIT;
    ge    = (st_i.n >= trial);
    st_d.n = ge ? (st_i.n - trial) : st_i.n;
    st_d.r = ge ? ((st_i.r >> 1) + BIT) : (st_i.r >> 1);
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ----- rtl/atl_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// atl_cordic_cell
// One vectoring cordic micro-rotation with its angle constant.
// ----------------------------------------------------------------------------
module atl_cordic_cell import atl_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic    clk_i,
  input  cordic_t st_i,
  output cordic_t st_o
);

  localparam logic signed [ZW-1:0] ANG = ATAN_TAB[STAGE];

  cordic_t              st_d;
  cordic_t              st_q;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic                 pos;

  // rotate towards y equal zero
  always_comb begin
    dx   = st_i.x >>> STAGE;
    dy   = st_i.y >>> STAGE;
    pos  = ~st_i.y[CW-1];
    st_d.x = pos ? (st_i.x + dy) : (st_i.x - dy);
    st_d.y = pos ? (st_i.y - dx) : (st_i.y + dx);
    st_d.z = pos ? (st_i.z + ANG) : (st_i.z - ANG);
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ----- rtl/accel_tilt_angles.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Tilt and plane angles from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Usage
//   Input: a sample beat is taken on each rising edge with start_i high;
//   busy_o stays low, so a new sample may come in every cycle.
//   Output: each result sits on result_o for one cycle with result_valid_o
//   high. The receiver cannot stall; results leave in input order.
//   Throughput: one sample per cycle sustained. A sample passes through
//   the 29-cell divider chain per axis, the 17-cell square root chains and
//   the cordic cell rows.
//   Configuration: a separate write channel, cfg_ready_o always high. The
//   range registers may only change while no sample is in flight.
//   Reset: the range registers take their defaults (265, 402, -90, 90) and
//   all in-flight samples are dropped.
//   Equal input range registers raise range_error with all angles zero.
// ----------------------------------------------------------------------------
module accel_tilt_angles import atl_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  accel_in_t        in_i,
  output logic             result_valid_o,
  output tilt_out_t        result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int LAT  = 3 + MAG_W + 3 + SQRT_STEPS + 1 + CORDIC_STAGES + 1;
  localparam int MDLY = 2 + SQRT_STEPS;
  localparam int SH   = ANG_FRAC - FRAC_BITS;
  localparam int HALF = (1 << SH) >> 1;

  // configuration registers
  logic signed [IN_W-1:0]  in_low_q, in_low_d, in_high_q, in_high_d;
  logic signed [OUT_W-1:0] out_low_q, out_low_d, out_high_q, out_high_d;

  logic                     in_acc;
  logic [LAT-1:0]           vld_q;
  logic signed [RNG_W-1:0]  rng;
  logic signed [DIFF_W-1:0] den;
  logic [DEN_W-1:0]         den_mag;
  logic                     range_err;
  logic signed [AXIS_W-1:0] ax [3];
  logic signed [AXIS_W-1:0] m_q [3];
  logic [SQ_W-1:0]          sq_q [3];
  logic [SQN_W-1:0]         sum_q [2];
  logic [ROOT_W-1:0]        root [2];
  logic signed [AXIS_W-1:0] mxd_q [MDLY];
  logic signed [AXIS_W-1:0] myd_q [MDLY];
  cordic_prep_t             prep_d [3];
  logic signed [ZW-1:0]     z_out [3];
  logic signed [ZW:0]       tx_w, ty_w, pa_w;
  tilt_out_t                result_d, result_q;

  function automatic logic signed [ZW-1:0] clamp_z(input logic signed [ZW-1:0] v,
                                                   input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r;
  endfunction

  // round half up to the output fraction width
  function automatic logic signed [ZW:0] to_frac(input logic signed [ZW:0] v);
    logic signed [ZW:0] s;
    s = v + (ZW+1)'(HALF);
    return s >>> SH;
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = start_i & ~busy_o;

  // register writes
  always_comb begin
    in_low_d   = in_low_q;
    in_high_d  = in_high_q;
    out_low_d  = out_low_q;
    out_high_d = out_high_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IN_LOW:   in_low_d   = cfg_data_i;
        CFG_IN_HIGH:  in_high_d  = cfg_data_i;
        CFG_OUT_LOW:  out_low_d  = cfg_data_i[OUT_W-1:0];
        CFG_OUT_HIGH: out_high_d = cfg_data_i[OUT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_low_q   <= IN_W'(265);
      in_high_q  <= IN_W'(402);
      out_low_q  <= -OUT_W'(90);
      out_high_q <= OUT_W'(90);
      vld_q      <= '0;
    end else begin
      in_low_q   <= in_low_d;
      in_high_q  <= in_high_d;
      out_low_q  <= out_low_d;
      out_high_q <= out_high_d;
      vld_q      <= {vld_q[LAT-2:0], in_acc};
    end
  end

  // range terms; the user must keep them fixed while samples are in flight, the block does not enforce it
  always_comb begin
    rng       = RNG_W'(out_high_q) - RNG_W'(out_low_q);
    den       = DIFF_W'(in_high_q) - DIFF_W'(in_low_q);
    den_mag   = den[DIFF_W-1] ? DEN_W'(-den) : DEN_W'(den);
    range_err = (in_high_q == in_low_q);
  end

  assign ax[0] = in_i.accel_x;
  assign ax[1] = in_i.accel_y;
  assign ax[2] = in_i.accel_z;

  // per axis: offset, scale, divide, offset and saturate, square
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [DIFF_W-1:0] diff_q;
    logic signed [PROD_W-1:0] prod_q;
    div_t                     div0_q;
    logic                     sgn0_q;
    logic [MAG_W-1:0]         sgn_q;
    div_t                     dst [MAG_W+1];
    logic signed [MAP_W-1:0]  qs;
    logic signed [MAP_W-1:0]  mv;
    logic signed [AXIS_W-1:0] msat;

    assign dst[0] = div0_q;

    for (genvar j = 0; j < MAG_W; j++) begin : g_div
      atl_div_cell u_cell (
        .clk_i (clk_i),
        .st_i  (dst[j]),
        .den_i (den_mag),
        .st_o  (dst[j+1])
      );
    end

    // signed quotient plus out_low, clipped to the axis width
    always_comb begin
      qs = {2'b00, dst[MAG_W].nq};
      mv = (sgn_q[MAG_W-1] ? -qs : qs) + MAP_W'(out_low_q);
      if (mv > MAP_W'(32767)) msat = AXIS_W'(32767);
      else if (mv < -MAP_W'(32768)) msat = -AXIS_W'(32768);
      else msat = AXIS_W'(mv);
    end

    always_ff @(posedge clk_i) begin
      diff_q     <= DIFF_W'(ax[a]) - DIFF_W'(in_low_q);
      prod_q     <= PROD_W'(diff_q) * PROD_W'(rng);
      div0_q.rem <= '0;
      div0_q.nq  <= prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
      sgn0_q     <= prod_q[PROD_W-1] ^ den[DIFF_W-1];
      sgn_q      <= {sgn_q[MAG_W-2:0], sgn0_q};
      m_q[a]     <= msat;
      sq_q[a]    <= SQ_W'(PROD_W'(m_q[a]) * PROD_W'(m_q[a]));
    end
  end

  // square sums: lane 0 is y z, lane 1 is x z
  always_ff @(posedge clk_i) begin
    sum_q[0] <= SQN_W'(sq_q[1]) + SQN_W'(sq_q[2]);
    sum_q[1] <= SQN_W'(sq_q[0]) + SQN_W'(sq_q[2]);
  end

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    sqrt_t sst [SQRT_STEPS+1];

    assign sst[0].n = sum_q[l];
    assign sst[0].r = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      atl_sqrt_cell #(
        .BIT_POS (2 * (SQRT_STEPS - 1 - k))
      ) u_cell (
        .clk_i (clk_i),
        .st_i  (sst[k]),
        .st_o  (sst[k+1])
      );
    end

    assign root[l] = sst[SQRT_STEPS].r[ROOT_W-1:0];
  end

  // mapped x and y wait for the roots
  always_ff @(posedge clk_i) begin
    mxd_q[0] <= m_q[0];
    myd_q[0] <= m_q[1];
    for (int i = 1; i < MDLY; i++) begin
      mxd_q[i] <= mxd_q[i-1];
      myd_q[i] <= myd_q[i-1];
    end
  end

  // cordic operands: tilt about x, tilt about y, plane angle
  always_comb begin
    prep_d[0] = cordic_prep(OP_W'(myd_q[MDLY-1]), OP_W'(root[1]));
    prep_d[1] = cordic_prep(OP_W'(mxd_q[MDLY-1]), OP_W'(root[0]));
    prep_d[2] = cordic_prep(-OP_W'(myd_q[MDLY-1]), -OP_W'(mxd_q[MDLY-1]));
  end

  for (genvar c = 0; c < 3; c++) begin : g_cordic
    cordic_prep_t         prep_q;
    cordic_t              cst [CORDIC_STAGES+1];
    logic                 sp_q [CORDIC_STAGES];
    logic signed [ZW-1:0] spz_q [CORDIC_STAGES];

    assign cst[0] = prep_q.st;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      atl_cordic_cell #(
        .STAGE (k)
      ) u_cell (
        .clk_i (clk_i),
        .st_i  (cst[k]),
        .st_o  (cst[k+1])
      );
    end

    // axis-aligned cases ride alongside the cells
    always_ff @(posedge clk_i) begin
      prep_q   <= prep_d[c];
      sp_q[0]  <= prep_q.sp;
      spz_q[0] <= prep_q.sp_z;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        sp_q[i]  <= sp_q[i-1];
        spz_q[i] <= spz_q[i-1];
      end
    end

    assign z_out[c] = sp_q[CORDIC_STAGES-1] ? spz_q[CORDIC_STAGES-1]
                                            : clamp_z(cst[CORDIC_STAGES].z, DEG_180);
  end

  // final clamps, plane offset, rounding and the range error override
  always_comb begin
    tx_w = (ZW+1)'(clamp_z(z_out[0], DEG_90));
    ty_w = (ZW+1)'(clamp_z(z_out[1], DEG_90));
    pa_w = (ZW+1)'(z_out[2]) + (ZW+1)'(DEG_180);
    result_d.tilt_about_x = range_err ? '0 : 16'(to_frac(tx_w));
    result_d.tilt_about_y = range_err ? '0 : 16'(to_frac(ty_w));
    result_d.plane_angle  = range_err ? '0 : 17'(to_frac(pa_w));
    result_d.range_error  = range_err;
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = vld_q[LAT-1];

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.range_error |->
      result_o.tilt_about_x == '0 && result_o.tilt_about_y == '0 &&
      result_o.plane_angle == '0)
    else $error("range error beat with nonzero angles");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> vld_q[0])
    else $error("accepted beat missing from the pipeline");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-2] |-> pa_w >= 0 && pa_w <= (ZW+1)'(2) * (ZW+1)'(DEG_180))
    else $error("plane angle outside 0 to 360 degrees");

endmodule
